[rtl/assert_macros.svh]
// assertion macros used by the top-level rtl file
// no dependencies; bodies are empty when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, sampled on the rising clock edge
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on the rising clock edge
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

[rtl/wrp_pkg.sv]
// types and constants of the wav riff header parser
// no dependencies; used by all rtl modules of the block
`default_nettype none

package wrp_pkg;

	// parser phases; codes above PH_HALT behave as halted
	typedef enum logic [2:0] {
		PH_RIFF = 3'd0,
		PH_CHDR = 3'd1,
		PH_BODY = 3'd2,
		PH_PAD  = 3'd3,
		PH_HALT = 3'd4
	} wrp_phase_t;

	// tags, first file byte in bits 31..24
	localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
	localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
	localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
	localparam logic [31:0] TAG_DATA = 32'h6461_7461;

	localparam int unsigned MIN_FILE_LEN = 44;
	localparam logic [31:0] MIN_FMT_LEN  = 32'd16;
	localparam logic [15:0] FMT_PCM      = 16'd1;
	localparam logic [15:0] MONO         = 16'd1;
	localparam logic [15:0] BITS_16      = 16'd16;

	// configuration register map
	localparam int unsigned  APB_ADDR_W        = 2;
	localparam logic [APB_ADDR_W-1:0] ADDR_EXPECTED_RATE = 2'd0;
	localparam logic [31:0]  EXPECTED_RATE_RST = 32'd16000;

	// stream widths
	localparam int unsigned IN_TDATA_W  = 8;
	localparam int unsigned OUT_TDATA_W = 128;
	localparam int unsigned OUT_TUSER_W = 2;

	// one result per file
	typedef struct packed {
		logic        parse_ok;
		logic [31:0] sample_rate;
		logic [15:0] channel_count;
		logic [15:0] sample_bits;
		logic [31:0] data_offset;
		logic [30:0] sample_count;
		logic        mono16_match;
	} wrp_result_t;

	// parser status seen by the top level
	typedef struct packed {
		wrp_phase_t phase;
		logic       err;
		logic       pos_zero;
	} wrp_status_t;

	// byte idx of a tag in file order
	function automatic logic [7:0] tag_byte(input logic [31:0] tag, input logic [1:0] idx);
		logic [7:0] b;
		case (idx)
			2'd0:    b = tag[31:24];
			2'd1:    b = tag[23:16];
			2'd2:    b = tag[15:8];
			default: b = tag[7:0];
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

[rtl/wav_riff_header_parser.sv]
// top level of the wav riff header parser: input register, parse core, result register
// depends on wrp_pkg, wrp_apb_regs, wrp_parse_core and assert_macros.svh
//
//   channel   dir   handshake          payload
//   s_*       in    s_tvalid/s_tready  tdata file byte, tlast final byte of file
//   m_*       out   m_tvalid/m_tready  tdata result fields, tuser flags
//   apb       in    psel/penable       expected_rate at address 0
//
// one byte per cycle while no last byte waits on an untaken result; the parse core updates
// its state as each beat leaves the input register, and the result of a file is loaded into the
// result register as its last byte leaves the input register.
// reset (arst_n low) clears the parse state; expected_rate returns to 16000.
// a last byte waits in the input register while an earlier result is not taken.
`default_nettype none
`include "assert_macros.svh"

module wav_riff_header_parser #(
	parameter int unsigned POSITION_BITS = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// slave side
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [wrp_pkg::IN_TDATA_W-1:0]       s_tdata,   // [7:0] file_byte
	input  logic                                 s_tlast,   // is_last
	// master side
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// [31:0] sample_rate, [47:32] channel_count, [63:48] sample_bits,
	// [95:64] data_offset, [126:96] sample_count, [127] zero
	output logic [wrp_pkg::OUT_TDATA_W-1:0]      m_tdata,
	// [0] parse_ok, [1] mono16_match
	output logic [wrp_pkg::OUT_TUSER_W-1:0]      m_tuser,
	// configuration
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [wrp_pkg::APB_ADDR_W-1:0]       paddr,
	input  logic [31:0]                          pwdata,
	output logic [31:0]                          prdata,
	output logic                                 pready
);
	import wrp_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic        core_en;
	logic        out_load;
	logic [31:0] expected_rate;

	wrp_result_t result;
	wrp_status_t status;

	logic                   m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;
	logic [OUT_TUSER_W-1:0] m_tuser_q;

	wrp_apb_regs u_regs (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.expected_rate(expected_rate)
	);

	// a byte moves on unless it is a last byte facing a full result register that is not being read
	assign core_en  = valid_s1 && (!last_s1 || !m_tvalid_q || m_tready);
	assign out_load = core_en && last_s1;
	assign s_tready = !valid_s1 || core_en;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	wrp_parse_core #(
		.POSITION_BITS(POSITION_BITS)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (core_en),
		.file_byte    (byte_s1),
		.is_last      (last_s1),
		.expected_rate(expected_rate),
		.result       (result),
		.status       (status)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {1'b0, result.sample_count, result.data_offset,
				result.sample_bits, result.channel_count, result.sample_rate};
			m_tuser_q <= {result.mono16_match, result.parse_ok};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// a finished file leaves the parser at the start of the riff header
	`ASSERT_NEXT(a_restart_after_last, clk, arst_n, out_load, (status.phase == PH_RIFF) && status.pos_zero, "parser did not restart after last byte")

	// halted parser always carries the error flag
	`ASSERT_IMPLIES(a_halt_has_err, clk, arst_n, status.phase == PH_HALT, status.err, "halted without error")

	// a last byte behind an untaken result holds the input side
	`ASSERT_IMPLIES(a_last_blocks_input, clk, arst_n, valid_s1 && last_s1 && m_tvalid_q && !m_tready, !s_tready && !core_en, "last byte advanced over a pending result")

endmodule

`default_nettype wire

[rtl/wrp_apb_regs.sv]
// apb configuration register: expected sample rate
// depends on wrp_pkg
`default_nettype none

module wrp_apb_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [wrp_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready,
	output logic [31:0]                      expected_rate
);
	import wrp_pkg::*;

	logic        wr_en;
	logic [31:0] rate_q;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & (paddr == ADDR_EXPECTED_RATE);

	// register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= EXPECTED_RATE_RST;
		end else if (wr_en) begin
			rate_q <= pwdata;
		end
	end

	// read mux
	assign prdata        = (paddr == ADDR_EXPECTED_RATE) ? rate_q : 32'd0;
	assign expected_rate = rate_q;

endmodule

`default_nettype wire

[rtl/wrp_parse_core.sv]
// per-byte parse state and result logic of the wav riff header parser
// depends on wrp_pkg
`default_nettype none

module wrp_parse_core #(
	parameter int unsigned POSITION_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic [7:0]           file_byte,
	input  logic                 is_last,
	input  logic [31:0]          expected_rate,
	output wrp_pkg::wrp_result_t result,
	output wrp_pkg::wrp_status_t status
);
	import wrp_pkg::*;

	// control state
	wrp_phase_t               phase_q, phase_n;
	logic [POSITION_BITS-1:0] pos_q, pos_inc;
	logic [31:0]              rem_q, rem_n;
	logic                     err_q, err_n;
	logic                     fmt_seen_q, fmt_seen_n;
	logic                     data_seen_q, data_seen_n;
	logic                     pad_q, pad_n;

	// chunk header and captures
	logic [31:0] tag_q, tag_n;
	logic [31:0] len_q, len_n;
	logic [15:0] fmtw_q, fmtw_n;
	logic [31:0] rate_q, rate_n;
	logic [15:0] chan_q, chan_n;
	logic [15:0] bits_q, bits_n;
	logic [31:0] doff_q, doff_n;
	logic [30:0] dcnt_q, dcnt_n;

	// helpers
	logic [63:0] pos_ext;
	logic [2:0]  hdr_k;
	logic [31:0] len_shift;
	logic [31:0] body_k;
	logic [31:0] rem_dec;
	logic [15:0] fmtw_hi;
	logic        ok;

	assign pos_inc   = (&pos_q) ? pos_q : pos_q + 1'b1;
	assign pos_ext   = 64'(pos_inc);
	assign hdr_k     = rem_q[2:0];
	assign len_shift = {file_byte, len_q[31:8]};
	assign body_k    = len_q - rem_q;
	assign rem_dec   = (rem_q != 32'd0) ? rem_q - 32'd1 : 32'd0;
	assign fmtw_hi   = {file_byte, fmtw_q[7:0]};

	// next state for one byte
	always_comb begin
		phase_n     = phase_q;
		rem_n       = rem_q;
		err_n       = err_q;
		fmt_seen_n  = fmt_seen_q;
		data_seen_n = data_seen_q;
		pad_n       = pad_q;
		tag_n       = tag_q;
		len_n       = len_q;
		fmtw_n      = fmtw_q;
		rate_n      = rate_q;
		chan_n      = chan_q;
		bits_n      = bits_q;
		doff_n      = doff_q;
		dcnt_n      = dcnt_q;
		case (phase_q)
			PH_RIFF: begin
				// position stays below 12 in this phase
				if ((pos_q[3:2] == 2'd0) && (file_byte != tag_byte(TAG_RIFF, pos_q[1:0]))) begin
					err_n   = 1'b1;
					phase_n = PH_HALT;
				end else if ((pos_q[3:2] == 2'd2) &&
					(file_byte != tag_byte(TAG_WAVE, pos_q[1:0]))) begin
					err_n   = 1'b1;
					phase_n = PH_HALT;
				end else if (pos_q[3:0] == 4'd11) begin
					phase_n = PH_CHDR;
					rem_n   = 32'd0;
				end
			end
			PH_CHDR: begin
				if (!hdr_k[2]) begin
					tag_n = {tag_q[23:0], file_byte};
				end else begin
					len_n = len_shift;
				end
				if (hdr_k == 3'd7) begin
					// full header: tag is complete, length takes this byte
					if ((tag_q == TAG_FMT) && (len_shift < MIN_FMT_LEN)) begin
						err_n   = 1'b1;
						phase_n = PH_HALT;
					end else if ((tag_q == TAG_DATA) && !fmt_seen_q) begin
						err_n   = 1'b1;
						phase_n = PH_HALT;
					end else begin
						if (tag_q == TAG_FMT) begin
							fmtw_n     = 16'd0;
							rate_n     = 32'd0;
							chan_n     = 16'd0;
							bits_n     = 16'd0;
							fmt_seen_n = 1'b1;
						end else if (tag_q == TAG_DATA) begin
							doff_n      = pos_ext[31:0];
							dcnt_n      = len_shift[31:1];
							data_seen_n = 1'b1;
						end
						pad_n = len_shift[0];
						if (len_shift == 32'd0) begin
							rem_n   = 32'd0;
							phase_n = PH_CHDR;
						end else if (is_last) begin
							err_n   = 1'b1;
							phase_n = PH_HALT;
						end else begin
							rem_n   = len_shift;
							phase_n = PH_BODY;
						end
					end
				end else begin
					rem_n = {29'd0, hdr_k + 3'd1};
				end
			end
			PH_BODY: begin
				// fmt body captures by byte offset within the body
				if ((tag_q == TAG_FMT) && (body_k[31:4] == 28'd0)) begin
					case (body_k[3:0])
						4'd0:  fmtw_n[7:0]   = file_byte;
						4'd1:  fmtw_n[15:8]  = file_byte;
						4'd2:  chan_n[7:0]   = file_byte;
						4'd3:  chan_n[15:8]  = file_byte;
						4'd4:  rate_n[7:0]   = file_byte;
						4'd5:  rate_n[15:8]  = file_byte;
						4'd6:  rate_n[23:16] = file_byte;
						4'd7:  rate_n[31:24] = file_byte;
						4'd14: bits_n[7:0]   = file_byte;
						4'd15: bits_n[15:8]  = file_byte;
						default: ;
					endcase
				end
				if ((tag_q == TAG_FMT) && (body_k == 32'd1) && (fmtw_hi != FMT_PCM)) begin
					err_n   = 1'b1;
					phase_n = PH_HALT;
				end else if (rem_dec == 32'd0) begin
					rem_n   = 32'd0;
					phase_n = pad_q ? PH_PAD : PH_CHDR;
				end else if (is_last) begin
					rem_n   = rem_dec;
					err_n   = 1'b1;
					phase_n = PH_HALT;
				end else begin
					rem_n = rem_dec;
				end
			end
			PH_PAD: begin
				phase_n = PH_CHDR;
				rem_n   = 32'd0;
			end
			default: ;
		endcase
	end

	// result from the updated state
	always_comb begin
		ok     = !err_n && fmt_seen_n && data_seen_n &&
			(pos_inc >= POSITION_BITS'(MIN_FILE_LEN));
		result = '0;
		if (ok) begin
			result.parse_ok      = 1'b1;
			result.sample_rate   = rate_n;
			result.channel_count = chan_n;
			result.sample_bits   = bits_n;
			result.data_offset   = doff_n;
			result.sample_count  = dcnt_n;
			result.mono16_match  = (chan_n == MONO) && (bits_n == BITS_16) &&
				(rate_n == expected_rate);
		end
	end

	// control registers; the last byte restarts the parser
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_RIFF;
			pos_q       <= '0;
			rem_q       <= '0;
			err_q       <= 1'b0;
			fmt_seen_q  <= 1'b0;
			data_seen_q <= 1'b0;
			pad_q       <= 1'b0;
		end else if (en) begin
			if (is_last) begin
				phase_q     <= PH_RIFF;
				pos_q       <= '0;
				rem_q       <= '0;
				err_q       <= 1'b0;
				fmt_seen_q  <= 1'b0;
				data_seen_q <= 1'b0;
				pad_q       <= 1'b0;
			end else begin
				phase_q     <= phase_n;
				pos_q       <= pos_inc;
				rem_q       <= rem_n;
				err_q       <= err_n;
				fmt_seen_q  <= fmt_seen_n;
				data_seen_q <= data_seen_n;
				pad_q       <= pad_n;
			end
		end
	end

	// header and capture registers
	always_ff @(posedge clk) begin
		if (en) begin
			tag_q  <= tag_n;
			len_q  <= len_n;
			fmtw_q <= fmtw_n;
			rate_q <= rate_n;
			chan_q <= chan_n;
			bits_q <= bits_n;
			doff_q <= doff_n;
			dcnt_q <= dcnt_n;
		end
	end

	assign status.phase    = phase_q;
	assign status.err      = err_q;
	assign status.pos_zero = (pos_q == '0);

endmodule

`default_nettype wire
